@@ src/priority_command_queue_top_assert.svh @@
// Assertion macros for the priority command queue
`ifndef PRIORITY_COMMAND_QUEUE_TOP_ASSERT_SVH
`define PRIORITY_COMMAND_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PCQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PCQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PCQ_ASSERT(lbl, prop, msg)
`define PCQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/pcq_pkg.sv @@
package pcq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OPCODE_W  = 2;
    localparam int KIND_W    = 8;
    localparam int PRIO_W    = 8;
    localparam int PARAM_W   = 32;
    localparam int STATION_W = 8;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [PRIO_W-1:0]    prio;
        logic [PARAM_W-1:0]   param;
        logic [STATION_W-1:0] station;
    } t_entry;

endpackage

@@ src/pcq_mem.sv @@
module pcq_mem #(
    parameter int DEPTH = pcq_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  pcq_pkg::t_entry          i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output pcq_pkg::t_entry          o_rd_data
);
    import pcq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/priority_command_queue_top.sv @@
// Push, clear and no-op: accepting the item registers S_EMIT, which then registers
// the result once the output is free. Pop: a scan reads every held entry through
// the single memory read port, then entries behind the picked one are moved down
// one slot each before the result is emitted.
// One item is worked on at a time; the next is accepted while a result waits.
// Reset (i_rst_n low, synchronous) empties the queue; memory contents are kept.
module priority_command_queue_top #(
    parameter int QUEUE_DEPTH = pcq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pcq_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [pcq_pkg::KIND_W-1:0]    i_cmd_kind,
    input  logic [pcq_pkg::PRIO_W-1:0]    i_prio,
    input  logic [pcq_pkg::PARAM_W-1:0]   i_param_word,
    input  logic [pcq_pkg::STATION_W-1:0] i_station_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pcq_pkg::STATUS_W-1:0]  o_status,
    output logic [pcq_pkg::KIND_W-1:0]    o_out_kind,
    output logic [pcq_pkg::PRIO_W-1:0]    o_out_prio,
    output logic [pcq_pkg::PARAM_W-1:0]   o_out_param,
    output logic [pcq_pkg::STATION_W-1:0] o_out_station,
    output logic [pcq_pkg::FILL_W-1:0]    o_fill
);
    import pcq_pkg::*;

    `include "priority_command_queue_top_assert.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_occ, n_occ;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_dv, n_dv;
    logic [AW-1:0]       r_didx, n_didx;
    logic [PRIO_W-1:0]   r_best, n_best;
    logic [AW-1:0]       r_pick, n_pick;
    t_entry              r_pick_ent, n_pick_ent;
    t_status             r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    t_entry              r_out_ent, n_out_ent;
    logic [FILL_W-1:0]   r_out_fill, n_out_fill;

    logic                accept;
    logic                out_free;
    logic                q_full;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    t_entry              rd_data;

    pcq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign q_full     = (r_occ == CW'(QUEUE_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_cnt        = r_cnt;
        n_dv         = 1'b0;
        n_didx       = r_cnt[AW-1:0];
        n_best       = r_best;
        n_pick       = r_pick;
        n_pick_ent   = r_pick_ent;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_ent    = r_out_ent;
        n_out_fill   = r_out_fill;
        wr_en        = 1'b0;
        wr_addr      = r_occ[AW-1:0];
        wr_data      = '{kind: i_cmd_kind, prio: i_prio, param: i_param_word,
                         station: i_station_id};
        rd_en        = 1'b0;
        rd_addr      = r_cnt[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pick_ent = '0;
                    n_status   = ST_OK;
                    n_state    = S_EMIT;
                    case (t_opcode'(i_opcode))
                        OP_PUSH: begin
                            if (q_full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en = 1'b1;
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_occ == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt   = '0;
                                n_best  = '0;
                                n_pick  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_occ = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt < r_occ) begin
                    rd_en = 1'b1;
                    n_dv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_dv) begin
                    if (rd_data.prio > r_best || r_didx == '0) begin
                        n_best     = rd_data.prio;
                        n_pick     = r_didx;
                        n_pick_ent = rd_data;
                    end
                end
                if (r_cnt == r_occ && !r_dv) begin
                    n_cnt   = CW'(r_pick) + CW'(1);
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (r_cnt < r_occ) begin
                    rd_en = 1'b1;
                    n_dv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_addr = r_didx - AW'(1);
                    wr_data = rd_data;
                end
                if (r_cnt >= r_occ && !r_dv) begin
                    n_occ   = r_occ - CW'(1);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_ent    = r_pick_ent;
                    n_out_fill   = FILL_W'(r_occ);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_cnt        <= n_cnt;
            r_dv         <= n_dv;
            r_didx       <= n_didx;
            r_best       <= n_best;
            r_pick       <= n_pick;
            r_pick_ent   <= n_pick_ent;
            r_status     <= n_status;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_ent    <= n_out_ent;
            r_out_fill   <= n_out_fill;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_kind    = r_out_ent.kind;
    assign o_out_prio    = r_out_ent.prio;
    assign o_out_param   = r_out_ent.param;
    assign o_out_station = r_out_ent.station;
    assign o_fill        = r_out_fill;

    `PCQ_ASSERT(a_occ_bound, r_occ <= CW'(QUEUE_DEPTH), "occupancy above depth")
    `PCQ_ASSERT(a_move_no_overlap, (wr_en && rd_en) |-> (wr_addr != rd_addr), "entry clash")
    `PCQ_ASSERT(a_full_drop, (r_state == S_EMIT && r_status == ST_FULL) |-> q_full, "bad drop")
    `PCQ_ASSERT(a_pick_in_range, (r_state == S_MOVE) |-> (CW'(r_pick) < r_occ), "pick range")

endmodule
